>>> design/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg: shared constants and types of the Huffman code bit packer
// Field layout of the input stream, opcodes, queue sizing, back-end states.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbp_pkg;

	// field widths of the input item
	localparam int SYMBOL_W  = 8;
	localparam int CODE_IN_W = 30;
	localparam int CLEN_W    = 5;
	localparam int BYTE_W    = 8;

	// tdata layout: symbol, code_bits, code_len, zero fill to whole bytes
	localparam int SYM_LSB   = 0;
	localparam int CODE_LSB  = SYM_LSB + SYMBOL_W;
	localparam int CLEN_LSB  = CODE_LSB + CODE_IN_W;
	localparam int FIELDS_W  = CLEN_LSB + CLEN_W;
	localparam int TDATA_W   = ((FIELDS_W + 7) / 8) * 8;

	// parameter defaults
	localparam int MAX_CODE_LEN_DEF = 30;
	localparam int SYMBOLS_DEF      = 256;

	// decoupling queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

	// opcodes carried on tuser
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_ENCODE = 1'b1;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_EMIT,
		BK_FLUSH
	} bk_state_t;

endpackage

`default_nettype wire

>>> design/hcbp_ram.sv
// ----------------------------------------------------------------------------
// hcbp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> design/hcbp_front.sv
// ----------------------------------------------------------------------------
// hcbp_front: input side of the bit packer
// Accepts beats, writes table loads, looks up codes of data bytes and
// pushes {final, length, masked code} into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_front #(
	parameter int MAX_CODE_LEN = 30,
	parameter int SYMBOLS      = 256
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        s_axis_tvalid,
	output logic                                        s_axis_tready,
	input  logic [hcbp_pkg::TDATA_W-1:0]                s_axis_tdata,
	input  logic                                        s_axis_tuser,
	input  logic                                        s_axis_tlast,
	input  logic [hcbp_pkg::LEVEL_W-1:0]                level,
	output logic                                        push,
	output logic [MAX_CODE_LEN+$clog2(MAX_CODE_LEN+1):0] push_data
);

	import hcbp_pkg::*;

	localparam int AW    = $clog2(SYMBOLS);
	localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
	localparam int EW    = MAX_CODE_LEN + LEN_W;

	logic                    accept;
	logic                    in_range;
	logic [SYMBOL_W-1:0]     sym;
	logic [CODE_IN_W-1:0]    cbits;
	logic [CLEN_W-1:0]       clen;
	logic [LEN_W-1:0]        len_sat;
	logic                    we;
	logic                    re;
	logic [EW-1:0]           wdata;
	logic [EW-1:0]           rdata;
	logic [LEN_W-1:0]        eff_len;
	logic [MAX_CODE_LEN-1:0] ones;
	logic [MAX_CODE_LEN-1:0] code_masked;

	logic valid_s1;
	logic fin_s1;
	logic inr_s1;

	assign sym   = s_axis_tdata[SYM_LSB +: SYMBOL_W];
	assign cbits = s_axis_tdata[CODE_LSB +: CODE_IN_W];
	assign clen  = s_axis_tdata[CLEN_LSB +: CLEN_W];

	// room for the beat in flight plus this one
	assign s_axis_tready = ({1'b0, level} + (LEVEL_W + 1)'(valid_s1))
		< (LEVEL_W + 1)'(QUEUE_DEPTH);
	assign accept   = s_axis_tvalid & s_axis_tready;
	assign in_range = {1'b0, sym} < (SYMBOL_W + 1)'(SYMBOLS);

	assign len_sat = (int'(clen) > MAX_CODE_LEN) ? LEN_W'(MAX_CODE_LEN) : LEN_W'(clen);
	assign wdata   = {len_sat, MAX_CODE_LEN'(cbits)};
	assign we      = accept & (s_axis_tuser == OP_LOAD) & in_range;
	assign re      = accept & (s_axis_tuser == OP_ENCODE);

	hcbp_ram #(
		.WIDTH (EW),
		.DEPTH (SYMBOLS)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (sym[AW-1:0]),
		.wdata (wdata),
		.re    (re),
		.raddr (sym[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= re;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			fin_s1 <= s_axis_tlast;
			inr_s1 <= in_range;
		end
	end

	// out-of-table byte appends nothing; bits above the length are dropped
	assign ones        = '1;
	assign eff_len     = inr_s1 ? rdata[EW-1:MAX_CODE_LEN] : '0;
	assign code_masked = rdata[MAX_CODE_LEN-1:0] & ~(ones << eff_len);

	assign push      = valid_s1;
	assign push_data = {fin_s1, eff_len, code_masked};

endmodule

`default_nettype wire

>>> design/hcbp_queue.sv
// ----------------------------------------------------------------------------
// hcbp_queue: short FIFO between front and back
// Register-based, QUEUE_DEPTH entries, exposes its fill level.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_queue #(
	parameter int WIDTH = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [WIDTH-1:0]             push_data,
	input  logic                         pop,
	output logic                         q_valid,
	output logic [WIDTH-1:0]             q_data,
	output logic [hcbp_pkg::LEVEL_W-1:0] level
);

	import hcbp_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	logic [WIDTH-1:0]   entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [LEVEL_W-1:0] level_q;

	assign q_valid = (level_q != '0);
	assign q_data  = entry_q[rd_ptr_q];
	assign level   = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + LEVEL_W'(1);
			end else if (pop && !push) begin
				level_q <= level_q - LEVEL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

>>> design/hcbp_back.sv
// ----------------------------------------------------------------------------
// hcbp_back: bit packing engine
// Appends one code to the pending bits, then emits a full byte per cycle
// unless stalled and, on a final byte, the zero-padded pending byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_back #(
	parameter int MAX_CODE_LEN = 30
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        q_valid,
	input  logic [MAX_CODE_LEN+$clog2(MAX_CODE_LEN+1):0] q_data,
	output logic                                        pop,
	output logic                                        m_axis_tvalid,
	input  logic                                        m_axis_tready,
	output logic [hcbp_pkg::BYTE_W-1:0]                 m_axis_tdata,
	output logic                                        m_axis_tlast,
	output logic                                        m_axis_tuser
);

	import hcbp_pkg::*;

	localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
	localparam int ACC_W = MAX_CODE_LEN + BYTE_W - 1;
	localparam int TOT_W = $clog2(MAX_CODE_LEN + 2 * BYTE_W);

	bk_state_t state_q;
	bk_state_t state_d;

	logic [MAX_CODE_LEN-1:0] q_code;
	logic [LEN_W-1:0]        q_len;
	logic                    q_fin;

	logic [ACC_W-1:0]  acc_q;
	logic [TOT_W-1:0]  tot_q;
	logic              fin_q;
	logic [BYTE_W-2:0] pend_q;   // right-aligned leftover bits
	logic [2:0]        used_q;

	logic              out_free;
	logic              tot_ge8;
	logic              emit;
	logic [BYTE_W-1:0] emit_byte;
	logic              emit_last;
	logic              emit_eom;
	logic [BYTE_W-1:0] sel_byte;
	logic [BYTE_W-1:0] flush_byte;

	assign {q_fin, q_len, q_code} = q_data;

	assign out_free   = !m_axis_tvalid || m_axis_tready;
	assign tot_ge8    = tot_q >= TOT_W'(BYTE_W);
	assign sel_byte   = BYTE_W'(acc_q >> (tot_q - TOT_W'(BYTE_W)));
	assign flush_byte = {pend_q, 1'b0} << (3'd7 - used_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					state_d = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (!tot_ge8) begin
					state_d = fin_q ? BK_FLUSH : BK_IDLE;
				end
			end
			BK_FLUSH: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		pop       = 1'b0;
		emit      = 1'b0;
		emit_byte = sel_byte;
		emit_last = 1'b0;
		emit_eom  = 1'b0;
		case (state_q)
			BK_IDLE: begin
				pop = q_valid;
			end
			BK_EMIT: begin
				emit      = tot_ge8 && out_free;
				emit_last = !fin_q && (tot_q < TOT_W'(2 * BYTE_W));
			end
			BK_FLUSH: begin
				emit      = out_free;
				emit_byte = flush_byte;
				emit_last = 1'b1;
				emit_eom  = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= BK_IDLE;
			pend_q        <= '0;
			used_q        <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			if (state_q == BK_EMIT && !tot_ge8) begin
				pend_q <= acc_q[BYTE_W-2:0] & ~({(BYTE_W - 1){1'b1}} << tot_q[2:0]);
				used_q <= tot_q[2:0];
			end else if (state_q == BK_FLUSH && out_free) begin
				pend_q <= '0;
				used_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			acc_q <= (ACC_W'(pend_q) << q_len) | ACC_W'(q_code);
			tot_q <= TOT_W'(used_q) + TOT_W'(q_len);
			fin_q <= q_fin;
		end else if (state_q == BK_EMIT && emit) begin
			tot_q <= tot_q - TOT_W'(BYTE_W);
		end
		if (emit) begin
			m_axis_tdata <= emit_byte;
			m_axis_tlast <= emit_last;
			m_axis_tuser <= emit_eom;
		end
	end

endmodule

`default_nettype wire

>>> design/huffman_code_bit_packer.sv
// ----------------------------------------------------------------------------
// huffman_code_bit_packer: Huffman encoder back end with bit packing
// Code table load, code lookup and MSB-first packing of codes into bytes.
// ----------------------------------------------------------------------------
// Load beats (tuser = 0) write one code table entry {code, length}; lengths
// above MAX_CODE_LEN saturate, loads to an index at or above SYMBOLS are
// dropped, and a load gives no output. Encode beats (tuser = 1) look up the
// code of the data byte and append it MSB-first to the pending bits; every
// byte that fills leaves as one output beat, earliest bits in the MSB. With
// tlast set on an encode beat the pending byte follows, zero-padded, even
// when empty, and carries tuser = 1; the packer then restarts empty. tlast
// on the output marks the last beat caused by one input beat. Table entries
// hold nothing defined until loaded; encoding an unloaded byte gives
// undefined data. A load beat ends in the front; an encode beat is popped
// into the packing engine, which then emits its N bytes in turn
// (up to 5 with the flush), and the engine handles one code at a time. The
// front does a registered table lookup and buffers up to four looked-up
// codes ahead of the engine, so input beats keep flowing while bytes drain.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_bit_packer #(
	parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
	parameter int SYMBOLS      = hcbp_pkg::SYMBOLS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// input stream
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [hcbp_pkg::TDATA_W-1:0] s_axis_tdata,  // symbol[7:0], code_bits[37:8],
	                                                    // code_len[42:38], zero[47:43]
	input  logic                         s_axis_tuser,  // opcode
	input  logic                         s_axis_tlast,  // final_byte
	// output stream
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [hcbp_pkg::BYTE_W-1:0]  m_axis_tdata,  // packed_byte
	output logic                         m_axis_tlast,  // last_of_run
	output logic                         m_axis_tuser   // end_of_message
);

	import hcbp_pkg::*;

	localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
	localparam int QW    = MAX_CODE_LEN + LEN_W + 1;   // {final, length, code}

	logic               push;
	logic [QW-1:0]      push_data;
	logic               pop;
	logic               q_valid;
	logic [QW-1:0]      q_data;
	logic [LEVEL_W-1:0] level;

	// front: accept, classify, table write / lookup
	hcbp_front #(
		.MAX_CODE_LEN (MAX_CODE_LEN),
		.SYMBOLS      (SYMBOLS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.level         (level),
		.push          (push),
		.push_data     (push_data)
	);

	// looked-up codes waiting for the packer
	hcbp_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.level     (level)
	);

	// back: packing engine and output register
	hcbp_back #(
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_data        (q_data),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	// a full queue must hold off the input
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(level == LEVEL_W'(QUEUE_DEPTH)) |-> !s_axis_tready)
		else $error("input accepted with queue full");

	// a lookup result always finds room
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (level < LEVEL_W'(QUEUE_DEPTH)) || pop)
		else $error("queue overflow");

	// the closing byte of a message is always the last beat of its input
	a_eom_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
		else $error("end of message without last");

endmodule

`default_nettype wire

>>> tb/huffman_code_bit_packer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_tb: self-checking bench for the Huffman bit packer
// Loads code table entries, encodes byte streams through them and checks
// every packed output beat against a cycle-free model of the packer kept in
// a small scoreboard, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_tb;
	import hcbp_pkg::*;

	localparam int HALF_PERIOD  = 10;
	localparam int MAX_IDLE     = 18;
	localparam int HOLD_CYCLES  = 200;  // long receiver hold-off, fills the front queue
	localparam int DRAIN_CYCLES = 40;   // engine may still be busy on zero-byte codes
	localparam int FIRST_RANDOM = 55;
	localparam int PRESSURE_RUN = 16;
	localparam int LAST_RANDOM  = 37;

	// one input beat, unpacked
	typedef struct packed {
		logic                 opcode;
		logic [SYMBOL_W-1:0]  symbol;
		logic [CODE_IN_W-1:0] code_bits;
		logic [CLEN_W-1:0]    code_len;
		logic                 final_byte;
	} code_item_t;

	// one output beat
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              run_end;   // tlast
		logic              msg_end;   // tuser
	} out_beat_t;

	// ------------------------------------------------------------------------
	// Scoreboard: holds its own code table and pending byte, turns every
	// accepted input beat into the packed bytes it must produce, and compares
	// each output beat with the oldest of them.
	// ------------------------------------------------------------------------
	class pack_scoreboard;
		logic [CODE_IN_W-1:0] code_mem [SYMBOLS_DEF];
		logic [CLEN_W-1:0]    len_mem  [SYMBOLS_DEF];
		logic [BYTE_W-1:0]    pend_byte;
		int unsigned          pend_bits;
		out_beat_t            expected_bytes[$];
		int                   errors;

		function new();
			foreach (code_mem[i]) begin
				code_mem[i] = '0;
				len_mem[i]  = '0;
			end
			pend_byte = '0;
			pend_bits = 0;
			errors    = 0;
		endfunction

		function void note_input(code_item_t it);
			logic [63:0] acc;
			logic [63:0] code;
			int unsigned len;
			int unsigned total;
			out_beat_t   beats[$];
			out_beat_t   b;
			if (it.opcode == OP_LOAD) begin
				// overlong lengths saturate; stray code bits are kept and masked on use
				code_mem[it.symbol] = it.code_bits;
				len_mem[it.symbol]  = (it.code_len > MAX_CODE_LEN_DEF) ?
				                      CLEN_W'(MAX_CODE_LEN_DEF) : it.code_len;
				return;
			end
			len   = len_mem[it.symbol];
			code  = 64'(code_mem[it.symbol]) & ((64'd1 << len) - 64'd1);
			// right-align the pending bits, append the code below them
			acc   = 64'(pend_byte) >> (8 - pend_bits);
			acc   = (acc << len) | code;
			total = pend_bits + len;
			while (total >= 8) begin
				b.data    = BYTE_W'(acc >> (total - 8));
				b.run_end = 1'b0;
				b.msg_end = 1'b0;
				beats.push_back(b);
				total -= 8;
			end
			acc       = acc & ((64'd1 << total) - 64'd1);
			pend_byte = BYTE_W'(acc << (8 - total));
			pend_bits = total;
			// closing byte goes out even when empty
			if (it.final_byte) begin
				b.data    = pend_byte;
				b.run_end = 1'b0;
				b.msg_end = 1'b1;
				beats.push_back(b);
				pend_byte = '0;
				pend_bits = 0;
			end
			if (beats.size() > 0) begin
				b = beats.pop_back();
				b.run_end = 1'b1;
				beats.push_back(b);
			end
			foreach (beats[i])
				expected_bytes.push_back(beats[i]);
		endfunction

		function void check(logic [BYTE_W-1:0] data, logic run_end, logic msg_end);
			out_beat_t e;
			if (expected_bytes.size() == 0) begin
				$error("unexpected output beat: tdata %02h tlast %0b tuser %0b",
				       data, run_end, msg_end);
				errors++;
				return;
			end
			e = expected_bytes.pop_front();
			if (data !== e.data) begin
				$error("packed_byte: expected %02h, actual %02h", e.data, data);
				errors++;
			end
			if (run_end !== e.run_end) begin
				$error("last_of_run: expected %0b, actual %0b", e.run_end, run_end);
				errors++;
			end
			if (msg_end !== e.msg_end) begin
				$error("end_of_message: expected %0b, actual %0b", e.msg_end, msg_end);
				errors++;
			end
		endfunction

		function int outstanding();
			return expected_bytes.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT signals; the inputs are known from time zero
	// ------------------------------------------------------------------------
	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [TDATA_W-1:0] s_axis_tdata  = '0;
	logic               s_axis_tuser  = 1'b0;
	logic               s_axis_tlast  = 1'b0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b1;
	logic [BYTE_W-1:0]  m_axis_tdata;
	logic               m_axis_tlast;
	logic               m_axis_tuser;

	pack_scoreboard scoreboard = new();

	// stimulus bookkeeping: only loaded entries are ever encoded
	logic [SYMBOL_W-1:0] loaded_syms[$];
	bit                  loaded[SYMBOLS_DEF];
	bit                  tx_burst    = 1'b0;  // sender runs gapless while set
	bit                  rx_burst    = 1'b0;  // receiver does not stall while set, but for a hold request
	bit                  rx_hold_req = 1'b0;  // asks the receiver for one long hold-off

	huffman_code_bit_packer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #HALF_PERIOD clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// item builders
	// ------------------------------------------------------------------------
	function automatic code_item_t load_item(int sym, logic [CODE_IN_W-1:0] code,
	                                         int len, bit fin);
		code_item_t it;
		it.opcode     = OP_LOAD;
		it.symbol     = SYMBOL_W'(sym);
		it.code_bits  = code;
		it.code_len   = CLEN_W'(len);
		it.final_byte = fin;
		if (!loaded[sym]) begin
			loaded[sym] = 1'b1;
			loaded_syms.push_back(SYMBOL_W'(sym));
		end
		return it;
	endfunction

	function automatic code_item_t encode_item(int sym, bit fin);
		code_item_t it;
		it.opcode     = OP_ENCODE;
		it.symbol     = SYMBOL_W'(sym);
		it.code_bits  = CODE_IN_W'($urandom);  // don't-care on encode, keep it noisy
		it.code_len   = CLEN_W'($urandom);
		it.final_byte = fin;
		return it;
	endfunction

	// mostly encodes of loaded bytes with short realistic codes, some reloads
	function automatic code_item_t random_item(bit encode_only);
		int pick;
		int len;
		if (!encode_only && $urandom_range(0, 4) == 0) begin
			pick = $urandom_range(0, 9);
			if (pick < 6)
				len = $urandom_range(1, 10);
			else if (pick < 8)
				len = $urandom_range(11, MAX_CODE_LEN_DEF);
			else if (pick == 8)
				len = 31;  // saturates
			else
				len = 0;
			return load_item($urandom_range(0, SYMBOLS_DEF - 1), CODE_IN_W'($urandom),
			                 len, $urandom_range(0, 1));
		end
		return encode_item(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
		                   $urandom_range(0, 5) == 0);
	endfunction

	function automatic int next_tx_gap();
		if ($urandom_range(0, 19) == 0)
			tx_burst = !tx_burst;
		return tx_burst ? 0 : $urandom_range(0, MAX_IDLE);
	endfunction

	// ------------------------------------------------------------------------
	// sender: one beat per call; valid stays high across back-to-back beats
	// ------------------------------------------------------------------------
	task automatic send_item(code_item_t it, int gap);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(TDATA_W - FIELDS_W){1'b0}}, it.code_len, it.code_bits, it.symbol};
		s_axis_tuser  <= it.opcode;
		s_axis_tlast  <= it.final_byte;
		do @(posedge clk); while (!s_axis_tready);
		scoreboard.note_input(it);
	endtask

	// ------------------------------------------------------------------------
	// receiver: random stall before each beat, plus one long hold on request
	// ------------------------------------------------------------------------
	initial begin : rx_side
		int stall;
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				stall = HOLD_CYCLES;
			end else begin
				if ($urandom_range(0, 29) == 0)
					rx_burst = !rx_burst;
				stall = rx_burst ? 0 : $urandom_range(0, MAX_IDLE);
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
				m_axis_tready <= 1'b1;
			end
			do @(posedge clk); while (!m_axis_tvalid);
			scoreboard.check(m_axis_tdata, m_axis_tlast, m_axis_tuser);
		end
	end

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin : stim
		code_item_t directed[$];
		int         n;

		// directed: zero length with stray bits, full 30-bit code, overlong
		// length with final set on a load, stray bits above a short code,
		// one-bit and exactly-one-byte codes
		directed.push_back(load_item(0,   30'h155,      0,  1'b0));
		directed.push_back(load_item(255, 30'h3FFFFFFF, 30, 1'b0));
		directed.push_back(load_item(1,   30'h2AAAAAAA, 31, 1'b1));
		directed.push_back(load_item(2,   30'h3FFFFFF5, 3,  1'b0));
		directed.push_back(load_item(128, 30'h1,        1,  1'b0));
		directed.push_back(load_item(127, 30'h3FFFFF01, 8,  1'b0));
		directed.push_back(encode_item(0,   1'b1));  // flush of an empty pending byte
		directed.push_back(encode_item(0,   1'b0));  // no output at all
		directed.push_back(encode_item(255, 1'b0));  // three full bytes, six bits left
		directed.push_back(encode_item(1,   1'b1));  // four bytes plus flush: five beats
		directed.push_back(encode_item(2,   1'b0));
		directed.push_back(encode_item(128, 1'b0));
		directed.push_back(encode_item(2,   1'b0));
		directed.push_back(encode_item(127, 1'b1));
		directed.push_back(encode_item(255, 1'b0));
		directed.push_back(encode_item(255, 1'b0));
		directed.push_back(encode_item(255, 1'b1));
		directed.push_back(load_item(255, 30'h0,        30, 1'b0));
		directed.push_back(encode_item(255, 1'b1));  // all-zero long code
		directed.push_back(load_item(5,   30'h2AAAAAAA, 17, 1'b0));
		directed.push_back(encode_item(5,   1'b0));
		directed.push_back(encode_item(0,   1'b1));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_item(directed[i], next_tx_gap());

		for (n = 0; n < FIRST_RANDOM; n++)
			send_item(random_item(1'b0), next_tx_gap());

		// receiver goes deaf for a while, sender keeps pushing encodes
		rx_hold_req = 1'b1;
		for (n = 0; n < PRESSURE_RUN; n++)
			send_item(random_item(1'b1), 0);

		// sender pauses until everything has drained
		s_axis_tvalid <= 1'b0;
		while (scoreboard.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		for (n = 0; n < LAST_RANDOM; n++)
			send_item(random_item(1'b0), next_tx_gap());
		s_axis_tvalid <= 1'b0;

		while (scoreboard.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (scoreboard.errors == 0)
			$display("huffman_code_bit_packer_tb OK");
		else
			$display("huffman_code_bit_packer_tb NOT OK");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin : watchdog
		#5_000_000;
		$display("huffman_code_bit_packer_tb NOT OK");
		$finish;
	end

endmodule

>>> filelist.f
design/hcbp_pkg.sv
design/hcbp_ram.sv
design/hcbp_front.sv
design/hcbp_queue.sv
design/hcbp_back.sv
design/huffman_code_bit_packer.sv
tb/huffman_code_bit_packer_tb.sv
